// ===== hw/rtl/timed_midi_event_table_macros.svh =====
// Assertion macros for the timed MIDI event table.
// Each macro checks a property on i_clk, disabled while i_rst_n is low.
`ifndef TIMED_MIDI_EVENT_TABLE_MACROS_SVH
`define TIMED_MIDI_EVENT_TABLE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define TMET_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("timed_midi_event_table: same-cycle check failed");
// Next-cycle implication.
`define TMET_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("timed_midi_event_table: next-cycle check failed");
`else
`define TMET_ASSERT_NOW(label, ante, cons)
`define TMET_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hw/rtl/tmet_pkg.sv =====
// Shared types and constants of the timed MIDI event table.
// No dependencies; the modules import this package.
package tmet_pkg;

    // Action codes of an input item.
    localparam logic [1:0] ACT_SCHED = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_FLUSH = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // Command queue geometry (depth must be a power of two).
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = 1;
    localparam int CMDQ_CNT_W = 2;

    typedef enum logic [1:0] {
        CMD_SCHED,
        CMD_TICK,
        CMD_FLUSH
    } t_cmd_kind;

    typedef struct packed {
        logic [7:0] status;
        logic [7:0] data1;
        logic [7:0] data2;
    } t_msg;

    typedef struct packed {
        t_msg        msg;
        logic [31:0] due;
    } t_entry;

    typedef struct packed {
        t_cmd_kind   kind;
        t_entry      entry;
        logic [31:0] now_time;
    } t_cmd;

endpackage

// ===== hw/rtl/tmet_in_if.sv =====
// Input channel of the timed MIDI event table: valid/ready plus one item.
// Depends on nothing.
interface tmet_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  msg_status;
    logic [7:0]  msg_data1;
    logic [7:0]  msg_data2;
    logic [31:0] due_time;
    logic [31:0] now_time;

    modport source (
        output valid, action, msg_status, msg_data1, msg_data2, due_time, now_time,
        input  ready
    );
    modport sink (
        input  valid, action, msg_status, msg_data1, msg_data2, due_time, now_time,
        output ready
    );
endinterface

// ===== hw/rtl/tmet_out_if.sv =====
// Output channel of the timed MIDI event table: valid/ready plus one fired message.
// Depends on nothing.
interface tmet_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_status;
    logic [7:0] out_data1;
    logic [7:0] out_data2;
    logic       out_last;

    modport source (
        output valid, out_status, out_data1, out_data2, out_last,
        input  ready
    );
    modport sink (
        input  valid, out_status, out_data1, out_data2, out_last,
        output ready
    );
endinterface

// ===== hw/rtl/timed_midi_event_table.sv =====
// Timed MIDI event table. A schedule item stores a three-byte message and its due
// tick in the lowest free slot (dropped if all SLOT_COUNT slots are full); a tick
// item fires every occupied slot whose due tick is strictly below the tick time,
// in slot order, marking the last one with out_last; a flush item frees all slots;
// action code 3 is ignored. The engine scans the slots of a tick through one read port
// of the entry memory, one slot per cycle while the output does not stall. A two-entry
// command queue lets the input side keep accepting items while a tick is scanned.
// Depends on tmet_pkg, tmet_in_if, tmet_out_if, tmet_front, tmet_cmd_fifo, tmet_back.
module timed_midi_event_table #(
    parameter int SLOT_COUNT = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tmet_in_if.sink    i_evt,
    tmet_out_if.source o_fire
);
    import tmet_pkg::*;

    `include "timed_midi_event_table_macros.svh"

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    t_cmd q_in_cmd;
    t_cmd q_out_cmd;

    // Front end classifies items.
    tmet_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_evt    (i_evt),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_cmd  (q_in_cmd)
    );

    // Decoupling queue.
    tmet_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd)
    );

    // Slot engine carries out the commands.
    tmet_back #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_out_cmd),
        .o_cmd_pop   (q_pop),
        .o_fire      (o_fire)
    );

    // The front end never pushes into a full queue, and the engine never pops an empty one.
    `TMET_ASSERT_NOW(a_no_push_when_full, q_push, !q_full)
    `TMET_ASSERT_NOW(a_no_pop_when_empty, q_pop, q_valid)
    // A tick command keeps the engine busy, so no pop follows it directly.
    `TMET_ASSERT_NEXT(a_tick_blocks_pop, q_pop && (q_out_cmd.kind == CMD_TICK), !q_pop)

endmodule

// ===== hw/rtl/tmet_front.sv =====
// Front end: accepts input items, classifies them into commands, feeds the queue.
// Depends on tmet_pkg and tmet_in_if.
module tmet_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tmet_in_if.sink       i_evt,
    input  logic          i_q_full,
    output logic          o_q_push,
    output tmet_pkg::t_cmd o_q_cmd
);
    import tmet_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;
    logic keep;

    // The holding register frees up whenever the queue takes its command.
    assign i_evt.ready = !r_valid || !i_q_full;
    assign accept      = i_evt.valid && i_evt.ready;
    assign keep        = accept && (i_evt.action != ACT_NONE);
    assign o_q_push    = r_valid && !i_q_full;
    assign o_q_cmd     = r_cmd;

    // Classify the item by its action code.
    always_comb begin
        n_cmd.entry.msg.status = i_evt.msg_status;
        n_cmd.entry.msg.data1  = i_evt.msg_data1;
        n_cmd.entry.msg.data2  = i_evt.msg_data2;
        n_cmd.entry.due        = i_evt.due_time;
        n_cmd.now_time         = i_evt.now_time;
        unique case (i_evt.action)
            ACT_SCHED: n_cmd.kind = CMD_SCHED;
            ACT_TICK:  n_cmd.kind = CMD_TICK;
            ACT_FLUSH: n_cmd.kind = CMD_FLUSH;
            ACT_NONE:  n_cmd.kind = CMD_FLUSH;
            default:   n_cmd.kind = CMD_FLUSH;
        endcase
    end

    // The unused action code is accepted and dropped here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (keep) begin
            r_valid <= 1'b1;
            r_cmd   <= n_cmd;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
    end

endmodule

// ===== hw/rtl/tmet_cmd_fifo.sv =====
// Short command queue between the front end and the slot engine.
// Depends on tmet_pkg.
module tmet_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tmet_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output tmet_pkg::t_cmd o_cmd
);
    import tmet_pkg::*;

    t_cmd                  r_slot [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr_ptr;
    logic [CMDQ_PTR_W-1:0] r_rd_ptr;
    logic [CMDQ_CNT_W-1:0] r_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_count == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Storage is payload only.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers wrap naturally at the power-of-two depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/tmet_back.sv =====
// Slot engine: stores scheduled messages, scans the table on a tick, frees all on flush.
// Depends on tmet_pkg and tmet_out_if.
module tmet_back #(
    parameter int SLOT_COUNT = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  tmet_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    tmet_out_if.source     o_fire
);
    import tmet_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    t_state            r_state;
    logic [SLOT_COUNT-1:0] r_busy;
    t_entry            r_mem [SLOT_COUNT];
    t_entry            r_rd_entry;
    logic [IDX_W-1:0]  r_idx;
    logic              r_issuing;
    logic              r_c_valid;
    logic [IDX_W-1:0]  r_c_idx;
    logic [31:0]       r_now;
    logic              r_p_valid;
    t_msg              r_p_msg;
    logic              r_o_valid;
    t_msg              r_o_msg;
    logic              r_o_last;

    logic              fire;
    logic              out_free;
    logic              stall;
    logic              advance;
    logic              issue;
    logic [IDX_W:0]    free_res;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
    logic              mem_we;

    // Lowest-numbered free slot, with a found flag on top.
    function automatic logic [IDX_W:0] find_free(input logic [SLOT_COUNT-1:0] busy);
        logic [IDX_W:0] res;
        res = '0;
        for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
            if (!busy[k]) begin
                res = {1'b1, IDX_W'(k)};
            end
        end
        return res;
    endfunction

    assign free_res   = find_free(r_busy);
    assign free_found = free_res[IDX_W];
    assign free_idx   = free_res[IDX_W-1:0];

    // Scan pipeline control: a fired slot waits in the pending register so
    // the last one of a tick can be marked once the scan has ended.
    assign fire     = r_c_valid && r_busy[r_c_idx] && (r_now > r_rd_entry.due);
    assign out_free = !r_o_valid || o_fire.ready;
    assign stall    = fire && r_p_valid && !out_free;
    assign advance  = (r_state == ST_SCAN) && !stall;
    assign issue    = advance && r_issuing;

    assign o_cmd_pop = (r_state == ST_IDLE) && i_cmd_valid;
    assign mem_we    = o_cmd_pop && (i_cmd.kind == CMD_SCHED) && free_found;

    assign o_fire.valid      = r_o_valid;
    assign o_fire.out_status = r_o_msg.status;
    assign o_fire.out_data1  = r_o_msg.data1;
    assign o_fire.out_data2  = r_o_msg.data2;
    assign o_fire.out_last   = r_o_last;

    // Entry memory: one write port for scheduling, one registered read port for the scan.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[free_idx] <= i_cmd.entry;
        end
        if (issue) begin
            r_rd_entry <= r_mem[r_idx];
        end
    end

    // Sequencer, busy flags and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_busy    <= '0;
            r_issuing <= 1'b0;
            r_c_valid <= 1'b0;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && o_fire.ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        unique case (i_cmd.kind)
                            CMD_SCHED: begin
                                if (free_found) begin
                                    r_busy[free_idx] <= 1'b1;
                                end
                            end
                            CMD_TICK: begin
                                r_now     <= i_cmd.now_time;
                                r_idx     <= '0;
                                r_issuing <= 1'b1;
                                r_state   <= ST_SCAN;
                            end
                            CMD_FLUSH: begin
                                r_busy <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (advance) begin
                        r_c_valid <= issue;
                        r_c_idx   <= r_idx;
                        if (issue) begin
                            if (r_idx == LAST_IDX) begin
                                r_issuing <= 1'b0;
                            end else begin
                                r_idx <= r_idx + 1'b1;
                            end
                        end
                        if (fire) begin
                            r_busy[r_c_idx] <= 1'b0;
                            r_p_msg         <= r_rd_entry.msg;
                            r_p_valid       <= 1'b1;
                            if (r_p_valid) begin
                                r_o_valid <= 1'b1;
                                r_o_msg   <= r_p_msg;
                                r_o_last  <= 1'b0;
                            end
                        end
                    end
                    if (!r_issuing && !r_c_valid) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    // The message still pending is the last one of this tick.
                    if (!r_p_valid) begin
                        r_state <= ST_IDLE;
                    end else if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_msg   <= r_p_msg;
                        r_o_last  <= 1'b1;
                        r_p_valid <= 1'b0;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
